// ===== sv/rcyl_pkg.sv =====
// Shared widths, register indexes and the side-band record of the ray/cylinder pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package rcyl_pkg;

	localparam int A_W       = 36;   // a = dir_x^2 + dir_z^2
	localparam int H_W       = 52;   // h = dir . (origin - center) in the XZ plane
	localparam int DISC_W    = 104;  // discriminant
	localparam int ROOT_W    = 52;   // floor(sqrt(disc))
	localparam int REM_W     = 54;   // square-root partial remainder
	localparam int MAG_W     = 53;   // magnitude of a root numerator
	localparam int QUO_W     = 31;   // unsaturated distance magnitude
	localparam int DREM_W    = 67;   // divider partial remainder
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

	typedef struct packed {
		logic                  miss;
		logic signed [H_W-1:0] h;
		logic [A_W-1:0]        a;
		logic signed [31:0]    oy;
		logic signed [17:0]    vy;
	} side_t;

endpackage
`default_nettype wire

// ===== sv/rcyl_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side-band pass-through.
// Depends on rcyl_pkg.
`default_nettype none
module rcyl_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [rcyl_pkg::DISC_W-1:0]   in_rad,
	input  rcyl_pkg::side_t               in_side,
	output logic                          out_vld,
	output logic [rcyl_pkg::ROOT_W-1:0]   out_root,
	output rcyl_pkg::side_t               out_side
);
	import rcyl_pkg::*;

	localparam int NSTG = ROOT_W;

	logic              vld_s  [NSTG];
	logic [DISC_W-1:0] rad_s  [NSTG];
	logic [REM_W-1:0]  rem_s  [NSTG];
	logic [ROOT_W-1:0] root_s [NSTG];
	side_t             side_s [NSTG];

	genvar k;
	for (k = 0; k < NSTG; k++) begin : g_stg
		logic              v_in;
		logic [DISC_W-1:0] rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic [ROOT_W-1:0] root_in;
		side_t             side_in;

		if (k == 0) begin : g_first
			assign v_in    = in_vld;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_in[REM_W-3:0], rad_in[DISC_W-1 -: 2]};
		assign trial  = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_in << 2;
				side_s[k] <= side_in;
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[NSTG-1];
	assign out_root = root_s[NSTG-1];
	assign out_side = side_s[NSTG-1];

endmodule
`default_nettype wire

// ===== sv/rcyl_div.sv =====
// Two-lane pipelined restoring divider: near and far root numerators over a,
// scaled by 2^FRAC_BITS, truncated and saturated to 32 bits. Depends on rcyl_pkg.
`default_nettype none
module rcyl_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [rcyl_pkg::ROOT_W-1:0]  in_root,
	input  rcyl_pkg::side_t              in_side,
	output logic                         out_vld,
	output logic signed [31:0]           out_t_near,
	output logic signed [31:0]           out_t_far,
	output rcyl_pkg::side_t              out_side
);
	import rcyl_pkg::*;

	localparam int NW = MAG_W + FRAC_BITS;
	localparam int CW = (NW > DREM_W) ? NW : DREM_W;
	localparam logic [31:0] T_MAX = 32'h7fff_ffff;
	localparam logic [31:0] T_MIN = 32'h8000_0000;

	// numerators -h - s and -h + s, as sign and magnitude
	logic signed [MAG_W:0] hx, sx;
	logic signed [MAG_W:0] num [2];
	logic [MAG_W-1:0]      mag_nx [2];

	logic             vld_s1;
	side_t            side_s1;
	logic [1:0]       neg_s1;
	logic [MAG_W-1:0] mag_s1 [2];

	always_comb begin
		hx     = (MAG_W+1)'(in_side.h);
		sx     = (MAG_W+1)'(in_root);
		num[0] = -hx - sx;
		num[1] = -hx + sx;
		for (int l = 0; l < 2; l++) begin
			mag_nx[l] = num[l][MAG_W] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= in_side;
			neg_s1    <= {num[1][MAG_W], num[0][MAG_W]};
			mag_s1[0] <= mag_nx[0];
			mag_s1[1] <= mag_nx[1];
		end
	end

	// scale, and flag quotients that reach 2^31
	logic [NW-1:0]     nval [2];
	logic [1:0]        big_nx;
	logic [DREM_W-1:0] rem0_nx [2];

	logic              vld_s2;
	side_t             side_s2;
	logic [1:0]        neg_s2;
	logic [1:0]        big_s2;
	logic [DREM_W-1:0] rem_s2 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			nval[l]    = NW'(mag_s1[l]) << FRAC_BITS;
			big_nx[l]  = CW'(nval[l]) >= (CW'(side_s1.a) << QUO_W);
			rem0_nx[l] = DREM_W'(nval[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= side_s1;
			neg_s2    <= neg_s1;
			big_s2    <= big_nx;
			rem_s2[0] <= rem0_nx[0];
			rem_s2[1] <= rem0_nx[1];
		end
	end

	// one quotient bit per stage, most significant first
	logic              st_vld  [QUO_W];
	side_t             st_side [QUO_W];
	logic [1:0]        st_neg  [QUO_W];
	logic [1:0]        st_big  [QUO_W];
	logic [DREM_W-1:0] st_rem  [QUO_W][2];
	logic [QUO_W-1:0]  st_quo  [QUO_W][2];

	genvar k;
	for (k = 0; k < QUO_W; k++) begin : g_step
		localparam int BIT = QUO_W - 1 - k;

		logic              v_in;
		side_t             side_in;
		logic [1:0]        neg_in, big_in;
		logic [DREM_W-1:0] rem_in [2];
		logic [QUO_W-1:0]  quo_in [2];
		logic [DREM_W-1:0] dv;
		logic [DREM_W-1:0] rem_nx [2];
		logic [QUO_W-1:0]  quo_nx [2];

		if (k == 0) begin : g_first
			assign v_in    = vld_s2;
			assign side_in = side_s2;
			assign neg_in  = neg_s2;
			assign big_in  = big_s2;
			assign rem_in  = rem_s2;
			assign quo_in  = '{'0, '0};
		end else begin : g_next
			assign v_in    = st_vld[k-1];
			assign side_in = st_side[k-1];
			assign neg_in  = st_neg[k-1];
			assign big_in  = st_big[k-1];
			assign rem_in  = st_rem[k-1];
			assign quo_in  = st_quo[k-1];
		end

		always_comb begin
			dv = DREM_W'(side_in.a) << BIT;
			for (int l = 0; l < 2; l++) begin
				if (rem_in[l] >= dv) begin
					rem_nx[l] = rem_in[l] - dv;
					quo_nx[l] = quo_in[l] | (QUO_W'(1) << BIT);
				end else begin
					rem_nx[l] = rem_in[l];
					quo_nx[l] = quo_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_vld[k] <= 1'b0;
			end else if (en) begin
				st_vld[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_side[k] <= side_in;
				st_neg[k]  <= neg_in;
				st_big[k]  <= big_in;
				st_rem[k]  <= rem_nx;
				st_quo[k]  <= quo_nx;
			end
		end
	end

	// sign and saturate
	logic [31:0] t_nx [2];
	logic [31:0] qx   [2];

	logic        vld_s3;
	side_t       side_s3;
	logic [31:0] t_s3 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qx[l] = {1'b0, st_quo[QUO_W-1][l]};
			if (st_neg[QUO_W-1][l]) begin
				t_nx[l] = st_big[QUO_W-1][l] ? T_MIN : (~qx[l] + 32'd1);
			end else begin
				t_nx[l] = st_big[QUO_W-1][l] ? T_MAX : qx[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= st_vld[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= st_side[QUO_W-1];
			t_s3    <= t_nx;
		end
	end

	assign out_vld    = vld_s3;
	assign out_side   = side_s3;
	assign out_t_near = $signed(t_s3[0]);
	assign out_t_far  = $signed(t_s3[1]);

endmodule
`default_nettype wire

// ===== sv/ray_cylinder_intersect.sv =====
// Top level of the ray / finite Y-axis cylinder intersection pipeline.
// Depends on rcyl_pkg, rcyl_sqrt and rcyl_div.
//
// Usage:
//   Rays enter on the in_valid / in_ready channel (origin Q16.16, direction
//   18-bit signed with FRAC_BITS fraction bits); one result per ray leaves on
//   out_valid / out_ready as hit, distance and far_root, in arrival order.
//   The cylinder (base center, radius, height) is set through the write port
//   cfg_wr_en / cfg_index / cfg_wdata; write it only while no transaction is
//   in flight. Unknown indexes are ignored.
//   Throughput: one ray per clock while no stall holds the pipeline. A ray
//   passes the setup stages, the 52-stage square root (one root bit per
//   stage), the divider with its 31 quotient stages (one quotient bit per
//   stage) and the height-test stages.
//   Reset: the pipeline empties, center goes to 0, radius and height to 1.0.
//   Stall: while out_ready is low the output register holds; one further
//   result drops into a skid register, which then freezes the whole pipeline
//   and lowers in_ready until the output drains. Nothing is lost or repeated.
`default_nettype none
module ray_cylinder_intersect #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rcyl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [31:0]               origin_x,
	input  logic signed [31:0]               origin_y,
	input  logic signed [31:0]               origin_z,
	input  logic signed [17:0]               dir_x,
	input  logic signed [17:0]               dir_y,
	input  logic signed [17:0]               dir_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic signed [31:0]               distance,
	output logic                             far_root
);
	import rcyl_pkg::*;

	localparam int YW = 52 + FRAC_BITS;   // hit height, scaled by 2^FRAC_BITS

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0]        rad_q, hgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			rad_q <= 31'(1) << FRAC_BITS;
			hgt_q <= 31'(1) << FRAC_BITS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CENTER_X: cx_q  <= $signed(cfg_wdata);
				CFG_CENTER_Y: cy_q  <= $signed(cfg_wdata);
				CFG_CENTER_Z: cz_q  <= $signed(cfg_wdata);
				CFG_RADIUS:   rad_q <= cfg_wdata[30:0];
				CFG_HEIGHT:   hgt_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline enable: every stage advances together unless the skid
	// register holds a result
	// ---------------------------------------------------------------
	logic skid_v_q;
	logic en;

	assign en       = ~skid_v_q;
	assign in_ready = en;

	// ---------------------------------------------------------------
	// s1: offsets from the cylinder base
	// ---------------------------------------------------------------
	logic               vld_s1;
	logic signed [32:0] dx_s1, dz_s1, dyc_s1;
	logic signed [17:0] vx_s1, vy_s1, vz_s1;
	logic signed [31:0] oy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= {origin_x[31], origin_x} - {cx_q[31], cx_q};
			dz_s1  <= {origin_z[31], origin_z} - {cz_q[31], cz_q};
			dyc_s1 <= {cy_q[31], cy_q} - {origin_y[31], origin_y};
			vx_s1  <= dir_x;
			vy_s1  <= dir_y;
			vz_s1  <= dir_z;
			oy_s1  <= origin_y;
		end
	end

	// ---------------------------------------------------------------
	// s2: first products
	// ---------------------------------------------------------------
	logic signed [65:0] sqx, sqz;
	logic               vld_s2;
	logic signed [35:0] vxx_s2, vzz_s2;
	logic signed [50:0] px_s2, py_s2, pz_s2;
	logic [63:0]        dsx_s2, dsz_s2;
	logic [61:0]        rr_s2;
	logic signed [17:0] vy_s2;
	logic signed [31:0] oy_s2;

	always_comb begin
		sqx = dx_s1 * dx_s1;
		sqz = dz_s1 * dz_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vxx_s2 <= vx_s1 * vx_s1;
			vzz_s2 <= vz_s1 * vz_s1;
			px_s2  <= vx_s1 * dx_s1;
			py_s2  <= vy_s1 * dyc_s1;
			pz_s2  <= vz_s1 * dz_s1;
			dsx_s2 <= sqx[63:0];
			dsz_s2 <= sqz[63:0];
			rr_s2  <= rad_q * rad_q;
			vy_s2  <= vy_s1;
			oy_s2  <= oy_s1;
		end
	end

	// ---------------------------------------------------------------
	// s3: a, h, the facing test and the squared XZ offset
	// ---------------------------------------------------------------
	logic signed [35:0] a_sum;
	logic signed [52:0] dot;
	logic               vld_s3, miss_s3;
	logic [A_W-1:0]     a_s3;
	logic signed [H_W-1:0] h_s3;
	logic [64:0]        dsq_s3;
	logic [61:0]        rr_s3;
	logic signed [17:0] vy_s3;
	logic signed [31:0] oy_s3;

	always_comb begin
		a_sum = vxx_s2 + vzz_s2;
		dot   = 53'(py_s2) - 53'(px_s2) - 53'(pz_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= A_W'(a_sum);
			h_s3    <= H_W'(px_s2) + H_W'(pz_s2);
			miss_s3 <= dot[52] | (a_sum == '0);
			dsq_s3  <= {1'b0, dsx_s2} + {1'b0, dsz_s2};
			rr_s3   <= rr_s2;
			vy_s3   <= vy_s2;
			oy_s3   <= oy_s2;
		end
	end

	// ---------------------------------------------------------------
	// s4: e = r^2 - |d|^2 and |h| as sign and magnitude
	// ---------------------------------------------------------------
	logic [66:0]        e_diff;
	logic               vld_s4, miss_s4, eneg_s4;
	logic [65:0]        emag_s4;
	logic [H_W-1:0]     hmag_s4;
	logic [A_W-1:0]     a_s4;
	logic signed [H_W-1:0] h_s4;
	logic signed [17:0] vy_s4;
	logic signed [31:0] oy_s4;

	assign e_diff = {5'b0, rr_s3} - {2'b0, dsq_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eneg_s4 <= e_diff[66];
			emag_s4 <= e_diff[66] ? 66'(-e_diff) : e_diff[65:0];
			hmag_s4 <= h_s3[H_W-1] ? H_W'(-h_s3) : H_W'(h_s3);
			miss_s4 <= miss_s3;
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			vy_s4   <= vy_s3;
			oy_s4   <= oy_s3;
		end
	end

	// ---------------------------------------------------------------
	// s5: partial products of h^2 and a*|e|
	// ---------------------------------------------------------------
	logic               vld_s5, miss_s5, eneg_s5;
	logic [51:0]        phh_s5, phl_s5, pll_s5;
	logic [39:0]        pae_s5 [2][3];
	logic [A_W-1:0]     a_s5;
	logic signed [H_W-1:0] h_s5;
	logic signed [17:0] vy_s5;
	logic signed [31:0] oy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phh_s5 <= hmag_s4[51:26] * hmag_s4[51:26];
			phl_s5 <= hmag_s4[51:26] * hmag_s4[25:0];
			pll_s5 <= hmag_s4[25:0] * hmag_s4[25:0];
			for (int j = 0; j < 3; j++) begin
				pae_s5[0][j] <= a_s4[17:0] * emag_s4[22*j +: 22];
				pae_s5[1][j] <= a_s4[35:18] * emag_s4[22*j +: 22];
			end
			eneg_s5 <= eneg_s4;
			miss_s5 <= miss_s4;
			a_s5    <= a_s4;
			h_s5    <= h_s4;
			vy_s5   <= vy_s4;
			oy_s5   <= oy_s4;
		end
	end

	// ---------------------------------------------------------------
	// s6: first reduction
	// ---------------------------------------------------------------
	logic               vld_s6, miss_s6, eneg_s6;
	logic [DISC_W-1:0]  hsa_s6, hsb_s6;
	logic [57:0]        cae_s6 [3];
	logic [A_W-1:0]     a_s6;
	logic signed [H_W-1:0] h_s6;
	logic signed [17:0] vy_s6;
	logic signed [31:0] oy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsa_s6 <= {phh_s5, pll_s5};
			hsb_s6 <= DISC_W'(phl_s5) << 27;
			for (int j = 0; j < 3; j++) begin
				cae_s6[j] <= (58'(pae_s5[1][j]) << 18) + 58'(pae_s5[0][j]);
			end
			eneg_s6 <= eneg_s5;
			miss_s6 <= miss_s5;
			a_s6    <= a_s5;
			h_s6    <= h_s5;
			vy_s6   <= vy_s5;
			oy_s6   <= oy_s5;
		end
	end

	// ---------------------------------------------------------------
	// s7: h^2 and a*|e|
	// ---------------------------------------------------------------
	logic               vld_s7, miss_s7, eneg_s7;
	logic [DISC_W-1:0]  hsq_s7, ae_s7;
	logic [A_W-1:0]     a_s7;
	logic signed [H_W-1:0] h_s7;
	logic signed [17:0] vy_s7;
	logic signed [31:0] oy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsq_s7  <= hsa_s6 + hsb_s6;
			ae_s7   <= DISC_W'(cae_s6[0]) + (DISC_W'(cae_s6[1]) << 22)
				+ (DISC_W'(cae_s6[2]) << 44);
			eneg_s7 <= eneg_s6;
			miss_s7 <= miss_s6;
			a_s7    <= a_s6;
			h_s7    <= h_s6;
			vy_s7   <= vy_s6;
			oy_s7   <= oy_s6;
		end
	end

	// ---------------------------------------------------------------
	// s8: discriminant; mark the ray as a miss when it is negative
	// ---------------------------------------------------------------
	logic [DISC_W:0]   disc;
	logic              vld_s8;
	logic [DISC_W-1:0] rad_s8;
	side_t             side_s8;

	assign disc = eneg_s7 ? ({1'b0, hsq_s7} - {1'b0, ae_s7})
	                      : ({1'b0, hsq_s7} + {1'b0, ae_s7});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s8       <= disc[DISC_W-1:0];
			side_s8.miss <= miss_s7 | disc[DISC_W];
			side_s8.h    <= h_s7;
			side_s8.a    <= a_s7;
			side_s8.oy   <= oy_s7;
			side_s8.vy   <= vy_s7;
		end
	end

	// ---------------------------------------------------------------
	// Square root and the two root divisions
	// ---------------------------------------------------------------
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	rcyl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s8),
		.in_rad   (rad_s8),
		.in_side  (side_s8),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	logic               dv_vld;
	logic signed [31:0] dv_tn, dv_tf;
	side_t              dv_side;

	rcyl_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (sq_vld),
		.in_root    (sq_root),
		.in_side    (sq_side),
		.out_vld    (dv_vld),
		.out_t_near (dv_tn),
		.out_t_far  (dv_tf),
		.out_side   (dv_side)
	);

	// ---------------------------------------------------------------
	// s9: t * dir_y for both roots
	// ---------------------------------------------------------------
	logic               vld_s9, miss_s9;
	logic signed [49:0] pyn_s9, pyf_s9;
	logic signed [31:0] tn_s9, tf_s9, oy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pyn_s9  <= dv_tn * dv_side.vy;
			pyf_s9  <= dv_tf * dv_side.vy;
			tn_s9   <= dv_tn;
			tf_s9   <= dv_tf;
			oy_s9   <= dv_side.oy;
			miss_s9 <= dv_side.miss;
		end
	end

	// ---------------------------------------------------------------
	// s10: height window test and root selection
	// ---------------------------------------------------------------
	logic signed [YW-1:0] oy_sc, y_n, y_f, base_y, top_y;
	logic                 ok_n, ok_f;
	logic                 hit_nx, far_nx;
	logic signed [31:0]   dist_nx;

	logic                 vld_s10, hit_s10, far_s10;
	logic signed [31:0]   dist_s10;

	always_comb begin
		oy_sc  = YW'(oy_s9) <<< FRAC_BITS;
		y_n    = oy_sc + YW'(pyn_s9);
		y_f    = oy_sc + YW'(pyf_s9);
		base_y = YW'(cy_q) <<< FRAC_BITS;
		top_y  = (YW'(cy_q) + $signed(YW'(hgt_q))) <<< FRAC_BITS;
		ok_n   = (y_n >= base_y) && (y_n <= top_y);
		ok_f   = (y_f >= base_y) && (y_f <= top_y);
		hit_nx  = 1'b0;
		far_nx  = 1'b0;
		dist_nx = '0;
		if (!miss_s9) begin
			if (ok_n) begin
				hit_nx  = 1'b1;
				dist_nx = tn_s9;
			end else if (ok_f) begin
				hit_nx  = 1'b1;
				far_nx  = 1'b1;
				dist_nx = tf_s9;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s10  <= hit_nx;
			far_s10  <= far_nx;
			dist_s10 <= dist_nx;
		end
	end

	// ---------------------------------------------------------------
	// Output register and skid register
	// ---------------------------------------------------------------
	logic               out_valid_q;
	logic               out_hit_q, out_far_q;
	logic signed [31:0] out_dist_q;
	logic               skid_hit_q, skid_far_q;
	logic signed [31:0] skid_dist_q;
	logic               out_take;
	logic               load_from_skid, load_from_pipe, load_skid;

	always_comb begin
		out_take       = out_valid_q & out_ready;
		load_from_skid = skid_v_q & out_take;
		load_from_pipe = ~skid_v_q & vld_s10 & (~out_valid_q | out_ready);
		load_skid      = ~skid_v_q & vld_s10 & out_valid_q & ~out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else begin
			if (load_from_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
			if (load_from_pipe) begin
				out_valid_q <= 1'b1;
			end else if (out_take && !skid_v_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_hit_q  <= skid_hit_q;
			out_far_q  <= skid_far_q;
			out_dist_q <= skid_dist_q;
		end else if (load_from_pipe) begin
			out_hit_q  <= hit_s10;
			out_far_q  <= far_s10;
			out_dist_q <= dist_s10;
		end
		if (load_skid) begin
			skid_hit_q  <= hit_s10;
			skid_far_q  <= far_s10;
			skid_dist_q <= dist_s10;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign far_root  = out_far_q;
	assign distance  = out_dist_q;

endmodule
`default_nettype wire

// ===== verif/tb_ray_cylinder_intersect.sv =====
// Testbench for ray_cylinder_intersect: drives rays, predicts each result exactly.
// Depends on rcyl_pkg and the ray_cylinder_intersect RTL.
`timescale 1ns / 1ps
module tb_ray_cylinder_intersect;
	import rcyl_pkg::*;

	localparam int FRAC = 16;
	localparam int PIPE_LAT = 96;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic signed [17:0] vx, vy, vz;
	} ray_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] t_dist;
		logic               far;
	} isect_t;

	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 0, in_ready;
	logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic signed [17:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic out_valid, out_ready = 0, hit, far_root;
	logic signed [31:0] distance;

	// shadow copy of the cylinder registers
	logic signed [31:0] cyl_cx = 0, cyl_cy = 0, cyl_cz = 0;
	logic [30:0] cyl_rad = 31'd65536, cyl_hgt = 31'd65536;

	isect_t pending_isects[$];
	int n_mismatch = 0, n_results = 0, n_rays = 0, n_hits = 0;
	longint cycle_cnt = 0;
	bit quiet_out = 0, quiet_in = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	ray_cylinder_intersect DUT (.*);

	// Distance from a root numerator: truncate toward zero, saturate to 32 bits.
	function automatic logic signed [31:0] root_to_dist(logic signed [63:0] num,
			logic [63:0] a);
		logic [127:0] mag, quo;
		mag = num < 0 ? 128'(-num) : 128'(num);
		quo = (mag << FRAC) / a;
		if (quo >= 128'(64'h8000_0000))
			return num < 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return num < 0 ? -$signed(quo[31:0]) : $signed(quo[31:0]);
	endfunction

	function automatic bit within_span(logic signed [31:0] oy, logic signed [17:0] vy,
			logic signed [31:0] t);
		longint y, lo, hi;
		y = (longint'(oy) <<< FRAC) + longint'(t) * longint'(vy);
		lo = longint'(cyl_cy) <<< FRAC;
		hi = (longint'(cyl_cy) + longint'(cyl_hgt)) <<< FRAC;
		return y >= lo && y <= hi;
	endfunction

	function automatic isect_t predict_isect(ray_t r);
		isect_t res;
		longint dx, dz, dot, h;
		logic [63:0] a;
		logic signed [127:0] disc;
		logic [127:0] sq;
		logic [63:0] s;
		logic signed [31:0] t;
		res = '{0, 0, 0};
		dx = longint'(r.ox) - longint'(cyl_cx);
		dz = longint'(r.oz) - longint'(cyl_cz);
		dot = -dx * r.vx + (longint'(cyl_cy) - longint'(r.oy)) * r.vy - dz * r.vz;
		a = longint'(r.vx) * r.vx + longint'(r.vz) * r.vz;
		h = longint'(r.vx) * dx + longint'(r.vz) * dz;
		if (dot < 0 || a == 0) return res;
		disc = 128'(h) * 128'(h) + 128'(a) * 128'(cyl_rad) * 128'(cyl_rad)
			- 128'(a) * (128'(dx) * 128'(dx) + 128'(dz) * 128'(dz));
		if (disc < 0) return res;
		// integer square root, one bit at a time
		s = 0;
		for (int i = 63; i >= 0; i--) begin
			sq = 128'(s | (64'd1 << i));
			if (sq * sq <= 128'(disc)) s = s | (64'd1 << i);
		end
		t = root_to_dist(-h - longint'(s), a);
		if (within_span(r.oy, r.vy, t)) return '{1, t, 0};
		t = root_to_dist(-h + longint'(s), a);
		if (within_span(r.oy, r.vy, t)) return '{1, t, 1};
		return res;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_CENTER_X: cyl_cx = val;
			CFG_CENTER_Y: cyl_cy = val;
			CFG_CENTER_Z: cyl_cz = val;
			CFG_RADIUS:   cyl_rad = val[30:0];
			CFG_HEIGHT:   cyl_hgt = val[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic set_cylinder(logic [31:0] cx, cy, cz, rad, hgt);
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_CENTER_Z, cz);
		write_reg(CFG_RADIUS, rad);
		write_reg(CFG_HEIGHT, hgt);
	endtask

	// Send one ray; hold valid and payload until the transaction completes.
	// Valid stays high into the next ray unless an idle cycle comes between.
	task automatic send_ray(ray_t r);
		while (!quiet_in && $urandom_range(99) < 38) begin
			in_valid <= 0;
			@(negedge clk);
		end
		origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
		dir_x <= r.vx; dir_y <= r.vy; dir_z <= r.vz;
		in_valid <= 1;
		pending_isects.push_back(predict_isect(r));
		n_rays++;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Wait until the pipeline has drained, then let it settle.
	task automatic drain();
		in_valid <= 0;
		while (pending_isects.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
	endtask

	function automatic logic signed [17:0] rand_dir();
		case ($urandom_range(5))
			0: return 18'sd65536;
			1: return -18'sd65536;
			2: return $signed(18'($urandom));  // full field, past unit length too
			default: return $signed(18'($urandom_range(131072))) - 18'sd65536;
		endcase
	endfunction

	// Random ray: mostly aimed near the cylinder so hits are common.
	function automatic ray_t rand_ray();
		ray_t r;
		if ($urandom_range(3) == 0) begin
			r = '{$urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir()};
		end else begin
			r.ox = cyl_cx + $signed(32'($urandom_range(1 << 21))) - (1 << 20);
			r.oy = cyl_cy + $signed(32'($urandom_range(1 << 19)));
			r.oz = cyl_cz + $signed(32'($urandom_range(1 << 21))) - (1 << 20);
			r.vx = 18'((r.ox > cyl_cx ? -1 : 1) * $signed(18'($urandom_range(65536))));
			r.vz = 18'((r.oz > cyl_cz ? -1 : 1) * $signed(18'($urandom_range(65536))));
			r.vy = $signed(18'($urandom_range(65536))) - 18'sd32768;
		end
		return r;
	endfunction

	task automatic test_directed();
		ray_t r;
		// hit through the side, near root
		r = '{-32'sd196608, 32'sd32768, 0, 18'sd65536, 0, 0}; send_ray(r);
		// axis-parallel ray always misses
		r = '{0, -32'sd65536, 0, 0, 18'sd65536, 0}; send_ray(r);
		// pointing away
		r = '{-32'sd196608, 32'sd32768, 0, -18'sd65536, 0, 0}; send_ray(r);
		// from inside: near root behind the origin, still in the height window
		r = '{0, 32'sd32768, 0, 18'sd65536, 0, 0}; send_ray(r);
		// above the cylinder, crossing to hit the side via the near root
		r = '{-32'sd131072, 32'sd98304, 0, 18'sd46341, -18'sd46341, 0}; send_ray(r);
		// passes by, negative discriminant
		r = '{-32'sd196608, 32'sd32768, 32'sd196608, 18'sd65536, 0, 0}; send_ray(r);
		// field extremes
		r = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			-18'sd65536, -18'sd65536, -18'sd65536}; send_ray(r);
		r = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			18'sd65536, 18'sd65536, 18'sd65536}; send_ray(r);
		r = '{32'sh8000_0000, 0, 32'sh7fff_ffff, 18'sh1ffff, 18'sh20000, 18'sh1ffff};
		send_ray(r);
		r = '{-1, -1, -1, -18'sd1, -18'sd1, -18'sd1}; send_ray(r);
		// tiny direction, saturated distance
		r = '{-32'sd65536000, 32'sd32768, 0, 18'sd1, 0, 0}; send_ray(r);
		r = '{-32'sd196608, 32'sd32768, 0, 18'sd65536, 18'sd65536, 0}; send_ray(r);
		drain();
	endtask

	task automatic test_random_phase(int count);
		for (int i = 0; i < count; i++) send_ray(rand_ray());
		drain();
	endtask

	task automatic test_cylinder_settings();
		set_cylinder(32'sd65536, -32'sd32768, 32'sd131072, 32'sd131072, 32'sd262144);
		test_random_phase(200);
		// degenerate cylinder: zero radius, zero height
		set_cylinder(0, 0, 0, 0, 0);
		test_random_phase(100);
		// extreme registers
		set_cylinder(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff);
		test_random_phase(100);
		set_cylinder(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'hffff_ffff, 32'hffff_ffff);
		test_random_phase(100);
		set_cylinder(0, 0, 0, 32'sd1048576, 32'sd1048576);
		quiet_in = 1; quiet_out = 1;  // full-rate stretch
		test_random_phase(150);
		quiet_in = 0; quiet_out = 0;
	endtask

	// Drive out_ready at random, with a quiet stretch on request.
	always @(negedge clk) begin
		cycle_cnt++;
		if (!arst_n) out_ready <= 0;
		else out_ready <= quiet_out || ($urandom_range(99) >= 38);
	end

	// Check each result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			isect_t want;
			n_results++;
			if (pending_isects.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result hit=%0b", hit);
			end else begin
				want = pending_isects.pop_front();
				n_hits += want.hit;
				if (hit !== want.hit || distance !== want.t_dist || far_root !== want.far) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch %0d: exp hit=%0b dist=%0d far=%0b, got %0b %0d %0b",
							n_results, want.hit, want.t_dist, want.far, hit, distance,
							far_root);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1;
		test_directed();
		test_random_phase(288);
		test_cylinder_settings();
		$display("%0d rays, %0d results, %0d hits over six cylinder settings",
			n_rays, n_results, n_hits);
		if (n_mismatch == 0 && pending_isects.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
